// ===== rtl/core/shuffled_lcg_random_generator_top_defines.svh =====
// Assertion macros used by the port checker of the shuffled generator.
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLCG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slcg_pkg.sv =====
// Types and constants of the shuffled minimal-standard generator.
package slcg_pkg;

    localparam int VALUE_W = 31;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = VALUE_W + MULT_W;

    localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
    localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

    // Generator steps run before the table starts to fill.
    localparam int WARMUP_EXTRA = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_FOLD,
        ST_DRAW_MUL,
        ST_DRAW_FOLD,
        ST_DRAW_RD,
        ST_DRAW_WR
    } slcg_state_t;

    typedef struct packed {
        logic load_seed;  // load the sanitized seed into the generator
        logic mul;        // register the multiply and the index estimate
        logic fold;       // reduce the product mod 2^31-1 into the generator
        logic seed_step;  // count a seeding step and fill the table
        logic idx_fix;    // correct the index estimate
        logic rd;         // read the table at the index
        logic draw_wr;    // swap the table entry and present the word
    } slcg_cmd_t;

    typedef struct packed {
        logic seeded;     // previous output is nonzero
        logic seed_last;  // the current seeding step is the last one
        logic out_busy;   // the output register holds a word not yet taken
    } slcg_status_t;

endpackage

// ===== rtl/core/shuffled_lcg_random_generator_top.sv =====
// Top level of the shuffled minimal-standard random number generator.
// Draw word: DRAW_MUL, DRAW_FOLD, DRAW_RD, then DRAW_WR loads the result; the next word is taken in IDLE.
// A seed word, or a draw before any seed, first runs a SEED_MUL/SEED_FOLD step per warm-up step and table entry.
// The serial generator loop sets the rate: a multiply and a fold state per step, then a read
// and a write state per draw; a word still held on the output stalls the next draw's write.
// Reset (rst_n low, asynchronous) gives IDLE, generator 1, unseeded; the first seed fills the table.
module shuffled_lcg_random_generator_top #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] seed, [31] zero fill
    input  logic        s_axis_tuser,   // [0] kind: 0 draw, 1 reseed then draw
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [30:0] value, [31] zero fill
);
    import slcg_pkg::*;

    slcg_cmd_t          cmd;
    slcg_status_t       status;
    logic [VALUE_W-1:0] out_value;

    // The controller owns the input handshake; a word is taken only in IDLE,
    // while a finished word may still be waiting in the output register.
    slcg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the generator, the previous output, the table and
    // the output register that drives the master side.
    slcg_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_kind   (s_axis_tuser),
        .in_seed   (s_axis_tdata[VALUE_W-1:0]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value)
    );

    assign m_axis_tdata = {1'b0, out_value};

endmodule

// ===== rtl/core/slcg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slcg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/slcg_ctrl.sv =====
// Controller state machine that sequences seeding and drawing.
module slcg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_kind,
    output logic                  in_ready,
    input  slcg_pkg::slcg_status_t status,
    output slcg_pkg::slcg_cmd_t    cmd
);
    import slcg_pkg::*;

    slcg_state_t state_reg;
    slcg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // A draw before any seed seeds with one first.
                    if (in_kind || !status.seeded)
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_SEED_MUL;
                    end
                    else
                    begin
                        state_next = ST_DRAW_MUL;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SEED_FOLD;
            end
            ST_SEED_FOLD:
            begin
                cmd.fold      = 1'b1;
                cmd.seed_step = 1'b1;
                state_next    = status.seed_last ? ST_DRAW_MUL : ST_SEED_MUL;
            end
            ST_DRAW_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DRAW_FOLD;
            end
            ST_DRAW_FOLD:
            begin
                cmd.fold    = 1'b1;
                cmd.idx_fix = 1'b1;
                state_next  = ST_DRAW_RD;
            end
            ST_DRAW_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_DRAW_WR;
            end
            ST_DRAW_WR:
            begin
                if (!status.out_busy)
                begin
                    cmd.draw_wr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/slcg_datapath.sv =====
// Datapath: generator register, modular multiply, table index and shuffle table.
module slcg_datapath #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slcg_pkg::slcg_cmd_t               cmd,
    output slcg_pkg::slcg_status_t            status,
    input  logic                              in_kind,
    input  logic [slcg_pkg::VALUE_W-1:0]      in_seed,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [slcg_pkg::VALUE_W-1:0]      out_value
);
    import slcg_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + WARMUP_EXTRA);
    localparam int QW = $clog2(TABLE_ENTRIES) + 1;
    localparam int PW = VALUE_W + QW;
    localparam longint unsigned BUCKET =
        64'd1 + ((64'(LCG_MOD) - 64'd1) / 64'(TABLE_ENTRIES));
    localparam logic [PW-1:0] BUCKET_C = PW'(BUCKET);
    localparam logic [QW-1:0] ENTRIES_C = QW'(TABLE_ENTRIES);
    localparam logic [QW-1:0] LAST_IDX  = QW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] WARM_C    = CW'(WARMUP_EXTRA);
    localparam logic [CW-1:0] LAST_CNT  = CW'(TABLE_ENTRIES + WARMUP_EXTRA - 1);

    logic [VALUE_W-1:0] lcg_reg,   lcg_next;
    logic [VALUE_W-1:0] oidx_reg,  oidx_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [QW-1:0]      est_reg;
    logic [AW-1:0]      idx_reg;
    logic [CW-1:0]      cnt_reg,   cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;

    logic [VALUE_W-1:0] seed_raw;
    logic [VALUE_W-1:0] seed_clean;
    logic [VALUE_W:0]   fold_sum;
    logic [VALUE_W:0]   fold_red;
    logic [VALUE_W-1:0] fold_val;
    logic [PW-1:0]      est_prod;
    logic [PW-1:0]      lo_mul;
    logic [PW-1:0]      hi_mul;
    logic [PW-1:0]      oidx_ext;
    logic [QW-1:0]      q_fix;
    logic [QW-1:0]      q_clamp;
    logic [CW-1:0]      seed_pos;
    logic               warm;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [VALUE_W-1:0] ram_wr_data;
    logic [VALUE_W-1:0] ram_rd_data;

    // Zero and the modulus itself would lock the generator at zero.
    assign seed_raw   = in_kind ? in_seed : VALUE_W'(1);
    assign seed_clean = (seed_raw == '0 || seed_raw == LCG_MOD) ? VALUE_W'(1) : seed_raw;

    // 2^31 is congruent to 1, so the high part folds onto the low part.
    assign fold_sum = {1'b0, prod_reg[VALUE_W-1:0]} + (VALUE_W + 1)'(prod_reg[PROD_W-1:VALUE_W]);
    assign fold_red = (fold_sum >= {1'b0, LCG_MOD}) ? fold_sum - {1'b0, LCG_MOD} : fold_sum;
    assign fold_val = fold_red[VALUE_W-1:0];

    // Index estimate: floor(x * entries / 2^31) is within one of the true bucket.
    assign est_prod = PW'(oidx_reg) * PW'(TABLE_ENTRIES);
    assign oidx_ext = PW'(oidx_reg);
    assign lo_mul   = PW'(est_reg) * BUCKET_C;
    assign hi_mul   = lo_mul + BUCKET_C;

    always_comb
    begin
        if (hi_mul <= oidx_ext)
        begin
            q_fix = est_reg + QW'(1);
        end
        else if (lo_mul > oidx_ext)
        begin
            q_fix = est_reg - QW'(1);
        end
        else
        begin
            q_fix = est_reg;
        end
        q_clamp = (q_fix >= ENTRIES_C) ? LAST_IDX : q_fix;
    end

    // Seeding step n fills entry (entries + 7 - n) once past the warm-up.
    assign seed_pos = LAST_CNT - cnt_reg;
    assign warm     = cnt_reg >= WARM_C;

    always_comb
    begin
        lcg_next       = lcg_reg;
        oidx_next      = oidx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_seed)
        begin
            lcg_next = seed_clean;
            cnt_next = '0;
        end
        if (cmd.fold)
        begin
            lcg_next = fold_val;
        end
        if (cmd.seed_step)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == LAST_CNT)
            begin
                oidx_next = fold_val;
            end
        end
        if (cmd.draw_wr)
        begin
            oidx_next      = ram_rd_data;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg       <= VALUE_W'(1);
            oidx_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lcg_reg       <= lcg_next;
            oidx_reg      <= oidx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(lcg_reg) * PROD_W'(LCG_MULT);
            est_reg  <= est_prod[PW-1:VALUE_W];
        end
        if (cmd.idx_fix)
        begin
            idx_reg <= q_clamp[AW-1:0];
        end
        if (cmd.draw_wr)
        begin
            out_value_reg <= ram_rd_data;
        end
    end

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = lcg_reg;
        if (cmd.seed_step && warm)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = seed_pos[AW-1:0];
            ram_wr_data = fold_val;
        end
        else if (cmd.draw_wr)
        begin
            ram_wr_en = 1'b1;
        end
    end

    slcg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    assign status.seeded    = (oidx_reg != '0);
    assign status.seed_last = (cnt_reg == LAST_CNT);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

endmodule

// ===== rtl/core/slcg_checker.sv =====
// Port checker for the shuffled generator top level, with its bind.
`include "shuffled_lcg_random_generator_top_defines.svh"

module slcg_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // A stalled output word stays put.
    `SLCG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

    // Every delivered word lies in 1 .. 2^31-2 with the fill bit clear.
    `SLCG_ASSERT_NOW(a_out_range, m_axis_tvalid, !m_axis_tdata[31] && m_axis_tdata[30:0] != 31'd0 && m_axis_tdata[30:0] != 31'h7FFF_FFFF, "output word out of range")

    // One word is worked on at a time.
    `SLCG_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

    // No result can appear in the cycle right after an input word is taken.
    `SLCG_ASSERT_NEXT(a_no_instant_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared too early")

endmodule

bind shuffled_lcg_random_generator_top slcg_port_checker u_slcg_port_checker (.*);

// ===== verif/slcg_tb_pkg.sv =====
`timescale 1ns / 100ps
// Codes shared by the checker and the stimulus of the shuffled generator testbench.
package slcg_tb_pkg;

    typedef enum logic {
        KIND_DRAW = 1'b0,
        KIND_SEED = 1'b1
    } word_kind_t;

endpackage

// ===== verif/slcg_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts every generator word and compares it with the block's output stream.
module slcg_checker
    import slcg_pkg::*;
    import slcg_tb_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] seed, [31] zero fill
    input  logic        s_axis_tuser,   // [0] kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [30:0] value, [31] zero fill
    output int          mismatches,
    output int          outstanding
);

    // Width of the value range covered by one table slot.
    localparam longint BUCKET = 1 + (longint'(LCG_MOD) - 1) / longint'(TABLE_ENTRIES);

    logic [VALUE_W-1:0] gen_state;
    logic [VALUE_W-1:0] prev_output;
    logic [VALUE_W-1:0] shuffle[TABLE_ENTRIES];
    logic [VALUE_W-1:0] expected_values[$];
    int                 fail_count;

    function automatic logic [VALUE_W-1:0] mult_mod(input logic [VALUE_W-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(LCG_MULT);
        return VALUE_W'(prod % 64'(LCG_MOD));
    endfunction

    // Warm the generator up and fill the table with its last steps.
    function automatic void reseed_table(input logic [VALUE_W-1:0] s);
        logic [VALUE_W-1:0] x;
        x = s;
        if (x == '0 || x == LCG_MOD)
            x = 1;
        for (int j = TABLE_ENTRIES + WARMUP_EXTRA - 1; j >= 0; j--)
        begin
            x = mult_mod(x);
            if (j < TABLE_ENTRIES)
                shuffle[j] = x;
        end
        gen_state   = x;
        prev_output = shuffle[0];
    endfunction

    function automatic logic [VALUE_W-1:0] next_shuffled_value(input word_kind_t kind,
                                                               input logic [VALUE_W-1:0] seed);
        longint slot;
        if (kind == KIND_SEED)
            reseed_table(seed);
        else if (prev_output == '0)
            reseed_table(1);
        gen_state = mult_mod(gen_state);
        slot = longint'(prev_output) / BUCKET;
        if (slot >= TABLE_ENTRIES)
            slot = TABLE_ENTRIES - 1;
        prev_output   = shuffle[slot];
        shuffle[slot] = gen_state;
        return prev_output;
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        fail_count++;
        $display("%0t: mismatch in %s: got 0x%08h, expected 0x%08h", $realtime, what,
                 got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_state   = 1;
            prev_output = '0;
            foreach (shuffle[i])
                shuffle[i] = '0;
            expected_values.delete();
            fail_count  = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_values.push_back(next_shuffled_value(word_kind_t'(s_axis_tuser),
                                                              s_axis_tdata[VALUE_W-1:0]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_values.size() == 0)
                    report_mismatch("unexpected word", m_axis_tdata[VALUE_W-1:0], '0);
                else if (m_axis_tdata[VALUE_W-1:0] !== expected_values[0])
                    report_mismatch("value", m_axis_tdata[VALUE_W-1:0], expected_values[0]);
                if (expected_values.size() != 0)
                    void'(expected_values.pop_front());
            end
            mismatches  <= fail_count;
            outstanding <= expected_values.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the shuffled generator: clock, reset, stimulus, output stalls and verdict.
module tb_top;
    import slcg_tb_pkg::*;

    localparam int TABLE_ENTRIES = 32;
    // The watchdog limit leaves several times the length of a seed word or of a deliberate
    // output stall before giving up.
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 100;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    int mismatches;
    int outstanding;

    // Upper bounds of the per-word idle draws on each side; zero gives a stretch with no idling.
    int src_gap_max  = 0;
    int snk_gap_max  = 0;
    // Set by the stimulus to make the output side hold off once for a long stretch.
    bit hold_request = 1'b0;
    int idle_cycles  = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    shuffled_lcg_random_generator_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    slcg_checker #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Offers one word after a random idle gap and returns at the edge where it is taken.
    // The valid is only lowered when a gap follows, so back-to-back words keep it high
    // without a second assignment in the same time step.
    task automatic send_word(input word_kind_t kind, input logic [30:0] seed);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, seed};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Mostly draws, with a sprinkling of reseeds. Zero and the all-ones seed, which both
    // fall back to a seed of one, show up now and then. The seed field of a draw is
    // random too, since the block must ignore it.
    task automatic send_random_word();
        logic [30:0] seed;
        int          pick;
        pick = $urandom_range(0, 99);
        seed = 31'($urandom);
        if (pick == 0)
            seed = '0;
        else if (pick == 1)
            seed = '1;
        if (pick < 8)
            send_word(KIND_SEED, seed);
        else
            send_word(KIND_DRAW, seed);
    endtask

    // Stops offering and waits until the checker holds no more predictions. The first
    // edge lets the count catch up with a word accepted at the current edge.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Output side: for every word it idles for a random gap (or the long stretch
    // when asked), then keeps tready high until a word is taken.
    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
            begin
                hold = $urandom_range(0, snk_gap_max);
            end
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_DRAW;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The very first word is a draw with no seed before it, so the
        // block has to seed itself with one; its seed field is all ones and must be ignored.
        src_gap_max = 3;
        snk_gap_max = 3;
        send_word(KIND_DRAW, '1);
        repeat (3) send_word(KIND_DRAW, 31'($urandom));
        // A zero seed and a seed equal to the modulus both behave like a seed of one.
        send_word(KIND_SEED, '0);
        send_word(KIND_DRAW, '0);
        send_word(KIND_SEED, '1);
        send_word(KIND_DRAW, '1);
        send_word(KIND_SEED, 31'd1);
        // Largest legal seed, then alternating bit patterns so every seed bit takes both
        // values, and two seeds back to back.
        send_word(KIND_SEED, 31'h7FFF_FFFE);
        send_word(KIND_DRAW, 31'h2AAA_AAAA);
        send_word(KIND_SEED, 31'h5555_5555);
        send_word(KIND_SEED, 31'h2AAA_AAAA);
        repeat (4) send_word(KIND_DRAW, 31'($urandom));
        wait_for_drain();

        // Random part, in phases that change how both sides idle.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    src_gap_max = 0;
                    snk_gap_max = 0;
                end
                1:
                begin
                    src_gap_max = 9;
                    snk_gap_max = 9;
                end
                2:
                begin
                    src_gap_max = 0;
                    snk_gap_max = 9;
                end
                default:
                begin
                    src_gap_max = 9;
                    snk_gap_max = 0;
                end
            endcase
            // Once the output side holds off for a long stretch while words keep coming
            // back to back, so the result register fills and the input stalls.
            if (phase == 4)
            begin
                hold_request = 1'b1;
                repeat (8) send_word(KIND_DRAW, 31'($urandom));
            end
            repeat (PHASE_WORDS) send_random_word();
            // Once the input side pauses until every word has come out.
            if (phase == 6)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== shuffled_lcg_random_generator_top.f =====
+incdir+rtl/core
rtl/core/slcg_pkg.sv
rtl/core/slcg_ram.sv
rtl/core/slcg_ctrl.sv
rtl/core/slcg_datapath.sv
rtl/core/shuffled_lcg_random_generator_top.sv
rtl/core/slcg_checker.sv
verif/slcg_tb_pkg.sv
verif/slcg_checker.sv
verif/tb_top.sv
